// ===== sv/lru_kv_pkg.sv =====
// Package for the LRU key-value cache: opcode and status codes,
// fixed port widths of the command and result fields.
// No dependencies.
`default_nettype none

package lru_kv_pkg;

  localparam int unsigned OpcodeW   = 3;
  localparam int unsigned KeyPortW  = 32;
  localparam int unsigned ValPortW  = 32;
  localparam int unsigned CapPortW  = 4;
  localparam int unsigned StatusW   = 2;

  typedef enum logic [OpcodeW-1:0] {
    OP_GET    = 3'd0,
    OP_PUT    = 3'd1,
    OP_ERASE  = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_RESIZE = 3'd4
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_CAP = 2'd1,
    ST_BAD_OP   = 2'd2
  } status_e;

endpackage

`default_nettype wire

// ===== sv/lru_key_value_cache.sv =====
// Fully associative key-value cache with least-recently-used replacement.
// Slot keys are compared in parallel; each slot keeps an age rank.
// Depends on lru_kv_pkg.
//
//   port group   direction  qualifier          contents
//   command      in         start_i & !busy_o  opcode, key, value, capacity
//   result       out        done_o             found, value, occupancy,
//                                              capacity, status
//
// One command is taken every cycle; busy_o stays low.
// A command is registered at its transfer, evaluated against all slots in
// the next cycle, and its result is then registered from that evaluation.
// The state update is written at the same edge as the result, so a
// following command always sees it. The receiver cannot stall.
// Reset empties the cache and sets the capacity to DEPTH.
`default_nettype none

module lru_key_value_cache
  import lru_kv_pkg::*;
#(
  parameter int unsigned DEPTH       = 8,
  parameter int unsigned KEY_WIDTH   = 32,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  input  wire logic [OpcodeW-1:0]  opcode_i,
  input  wire logic [KeyPortW-1:0] lookup_key_i,
  input  wire logic [ValPortW-1:0] write_value_i,
  input  wire logic [CapPortW-1:0] new_capacity_i,
  output logic                     done_o,
  output logic                     found_o,
  output logic [ValPortW-1:0]      read_value_o,
  output logic [CapPortW-1:0]      occupancy_o,
  output logic [CapPortW-1:0]      current_capacity_o,
  output logic [StatusW-1:0]       status_o
);

  localparam int unsigned RankW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CountW = $clog2(DEPTH + 1);
  localparam int unsigned MagW   = (CountW > CapPortW) ? CountW : CapPortW;

  // command register
  logic                req_q;
  logic [OpcodeW-1:0]  op_q;
  logic [KeyPortW-1:0] key_q;
  logic [ValPortW-1:0] wval_q;
  logic [CapPortW-1:0] ncap_q;

  // slot state
  logic [KEY_WIDTH-1:0]   slot_key_q   [DEPTH];
  logic [VALUE_WIDTH-1:0] slot_value_q [DEPTH];
  logic [DEPTH-1:0]       valid_q, valid_d;
  logic [RankW-1:0]       rank_q [DEPTH];
  logic [RankW-1:0]       rank_d [DEPTH];
  logic [CountW-1:0]      count_q, count_d;
  logic [MagW-1:0]        cap_q, cap_d;

  // result register
  logic                done_q;
  logic                found_q, found_d;
  logic [ValPortW-1:0] rd_q, rd_d;
  logic [CapPortW-1:0] occ_q, cap_out_q;
  logic [StatusW-1:0]  status_q;
  status_e             status_d;

  logic                          accept;
  logic [KEY_WIDTH+KeyPortW-1:0] key_ext;
  logic [KEY_WIDTH-1:0]          key_in;
  logic [VALUE_WIDTH+ValPortW-1:0] wval_ext;
  logic [VALUE_WIDTH-1:0]        wval_in;
  logic [DEPTH-1:0]              hit, victim, vacant, free_slot, key_we;
  logic                          hit_any, evict;
  logic [RankW-1:0]              hit_rank;
  logic [VALUE_WIDTH-1:0]        hit_val;
  logic [VALUE_WIDTH+ValPortW-1:0] hit_val_ext;
  logic [MagW-1:0]               count_mag, count_d_mag, ncap_mag, ncap_sat;

  assign busy_o  = 1'b0;
  assign accept  = start_i && !busy_o;

  assign key_ext  = {KEY_WIDTH'(0), key_q};
  assign key_in   = key_ext[KEY_WIDTH-1:0];
  assign wval_ext = {VALUE_WIDTH'(0), wval_q};
  assign wval_in  = wval_ext[VALUE_WIDTH-1:0];

  assign count_mag = MagW'(count_q);
  assign ncap_mag  = MagW'(ncap_q);
  assign ncap_sat  = (ncap_mag > MagW'(DEPTH)) ? MagW'(DEPTH) : ncap_mag;
  assign evict     = (count_mag >= cap_q);

  always_comb begin
    hit_any  = 1'b0;
    hit_rank = '0;
    hit_val  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit[i]    = valid_q[i] && (slot_key_q[i] == key_in);
      victim[i] = valid_q[i] && ((MagW'(rank_q[i]) + MagW'(1)) == count_mag);
      hit_any   = hit_any | hit[i];
      hit_rank  = hit_rank | (hit[i] ? rank_q[i] : '0);
      hit_val   = hit_val | (hit[i] ? slot_value_q[i] : '0);
    end
  end

  assign hit_val_ext = {ValPortW'(0), hit_val};
  assign vacant      = ~valid_q | (evict ? victim : '0);

  always_comb begin
    logic taken;
    taken     = 1'b0;
    free_slot = '0;
    for (int i = 0; i < DEPTH; i++) begin
      free_slot[i] = vacant[i] && !taken;
      taken        = taken | vacant[i];
    end
  end

  always_comb begin
    valid_d  = valid_q;
    rank_d   = rank_q;
    count_d  = count_q;
    cap_d    = cap_q;
    key_we   = '0;
    found_d  = 1'b0;
    rd_d     = '0;
    status_d = ST_OK;
    if (req_q) begin
      unique case (op_e'(op_q))
        OP_GET, OP_PUT: begin
          if (hit_any) begin
            found_d = 1'b1;
            if (op_e'(op_q) == OP_GET) begin
              rd_d = hit_val_ext[ValPortW-1:0];
            end
            for (int i = 0; i < DEPTH; i++) begin
              if (hit[i]) begin
                rank_d[i] = '0;
              end else if (valid_q[i] && rank_q[i] < hit_rank) begin
                rank_d[i] = rank_q[i] + RankW'(1);
              end
            end
          end else if (op_e'(op_q) == OP_PUT) begin
            for (int i = 0; i < DEPTH; i++) begin
              if (evict && victim[i]) begin
                valid_d[i] = 1'b0;
                rank_d[i]  = '0;
              end else if (valid_q[i]) begin
                rank_d[i] = rank_q[i] + RankW'(1);
              end
              if (free_slot[i]) begin
                valid_d[i] = 1'b1;
                rank_d[i]  = '0;
              end
            end
            key_we  = free_slot;
            count_d = evict ? count_q : count_q + CountW'(1);
          end
        end
        OP_ERASE: begin
          if (hit_any) begin
            found_d = 1'b1;
            for (int i = 0; i < DEPTH; i++) begin
              if (hit[i]) begin
                valid_d[i] = 1'b0;
                rank_d[i]  = '0;
              end else if (valid_q[i] && rank_q[i] > hit_rank) begin
                rank_d[i] = rank_q[i] - RankW'(1);
              end
            end
            count_d = count_q - CountW'(1);
          end
        end
        OP_CLEAR: begin
          valid_d = '0;
          for (int i = 0; i < DEPTH; i++) begin
            rank_d[i] = '0;
          end
          count_d = '0;
        end
        OP_RESIZE: begin
          if (ncap_q == '0) begin
            status_d = ST_ZERO_CAP;
          end else begin
            cap_d = ncap_sat;
            for (int i = 0; i < DEPTH; i++) begin
              if (valid_q[i] && MagW'(rank_q[i]) >= ncap_sat) begin
                valid_d[i] = 1'b0;
                rank_d[i]  = '0;
              end
            end
            if (count_mag > ncap_sat) begin
              count_d = CountW'(ncap_sat);
            end
          end
        end
        default: begin
          status_d = ST_BAD_OP;
        end
      endcase
    end
  end

  assign count_d_mag = MagW'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q   <= 1'b0;
      done_q  <= 1'b0;
      valid_q <= '0;
      count_q <= '0;
      cap_q   <= MagW'(DEPTH);
      for (int i = 0; i < DEPTH; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      req_q   <= accept;
      done_q  <= req_q;
      valid_q <= valid_d;
      count_q <= count_d;
      cap_q   <= cap_d;
      rank_q  <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= opcode_i;
      key_q  <= lookup_key_i;
      wval_q <= write_value_i;
      ncap_q <= new_capacity_i;
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (key_we[i]) begin
        slot_key_q[i] <= key_in;
      end
      if (key_we[i] || (req_q && op_e'(op_q) == OP_PUT && hit[i])) begin
        slot_value_q[i] <= wval_in;
      end
    end
    found_q   <= found_d;
    rd_q      <= rd_d;
    occ_q     <= count_d_mag[CapPortW-1:0];
    cap_out_q <= cap_d[CapPortW-1:0];
    status_q  <= status_d;
  end

  assign done_o             = done_q;
  assign found_o            = found_q;
  assign read_value_o       = rd_q;
  assign occupancy_o        = occ_q;
  assign current_capacity_o = cap_out_q;
  assign status_o           = status_q;

  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) == $countones(valid_q))
    else $error("entry count differs from number of valid slots");

  a_count_within_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_mag <= cap_q)
    else $error("entry count exceeds capacity");

  a_cap_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cap_q != '0 && cap_q <= MagW'(DEPTH))
    else $error("capacity out of range");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 done_o)
    else $error("result strobe missing two cycles after transfer");

endmodule

`default_nettype wire
